// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BGCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define BGCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bgcc_pkg.sv -----
`timescale 1ns / 1ps

package bgcc_pkg;

    localparam int NREG            = 7;
    localparam int DENOM_W         = 16;
    localparam int CFG_IDX_W       = 4;
    localparam int RESULT_W        = 64;
    localparam int DEF_MAX_DENOMS  = 7;
    localparam int DEF_AMOUNT_BITS = 16;

    typedef logic [NREG-1:0][DENOM_W-1:0] denom_arr_t;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT = 4'd7;
    localparam logic [2:0]           ACTIVE_RESET     = 3'd7;

    localparam denom_arr_t DENOM_RESET = {16'd50, 16'd25, 16'd20, 16'd10,
                                          16'd5, 16'd2, 16'd1};

endpackage

// ----- design/bgcc_div.sv -----
`timescale 1ns / 1ps

module bgcc_div #(
    parameter int W = bgcc_pkg::DEF_AMOUNT_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [W-1:0]                 dividend,
    input  logic [bgcc_pkg::DENOM_W-1:0] divisor,
    output logic                         done,
    output logic [W-1:0]                 quot,
    output logic [W-1:0]                 rem
);
    import bgcc_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CW-1:0]      cnt_reg;
    logic [DENOM_W-1:0] r_reg;
    logic [DENOM_W-1:0] dv_reg;
    logic [W-1:0]       q_reg;
    logic [DENOM_W:0]   trial;
    logic [DENOM_W:0]   diff;
    logic               fits;

    assign trial = {r_reg, q_reg[W-1]};
    assign diff  = trial - {1'b0, dv_reg};
    assign fits  = trial >= {1'b0, dv_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg  <= '0;
            q_reg  <= dividend;
            dv_reg <= divisor;
        end
        else if (busy_reg)
        begin
            r_reg <= fits ? diff[DENOM_W-1:0] : trial[DENOM_W-1:0];
            q_reg <= {q_reg[W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = W'(r_reg);

endmodule

// ----- design/bgcc_ctrl.sv -----
`timescale 1ns / 1ps

module bgcc_ctrl #(
    parameter int MAX_DENOMS  = bgcc_pkg::DEF_MAX_DENOMS,
    parameter int AMOUNT_BITS = bgcc_pkg::DEF_AMOUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [15:0]                   amount,
    input  bgcc_pkg::denom_arr_t          denoms,
    input  logic [2:0]                    active_count,
    output logic                          div_start,
    output logic [AMOUNT_BITS-1:0]        div_dividend,
    output logic [bgcc_pkg::DENOM_W-1:0]  div_divisor,
    input  logic                          div_done,
    input  logic [AMOUNT_BITS-1:0]        div_quot,
    input  logic [AMOUNT_BITS-1:0]        div_rem,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bgcc_pkg::RESULT_W-1:0] m_data,
    output logic                          m_last
);
    import bgcc_pkg::*;

    localparam int W   = AMOUNT_BITS;
    localparam int TW  = AMOUNT_BITS + 1;
    localparam int LIM = (MAX_DENOMS < NREG) ? MAX_DENOMS : NREG;
    localparam int IW  = (LIM > 1) ? $clog2(LIM) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_STEP,
        ST_WAIT,
        ST_ADV,
        ST_EVAL,
        ST_OUT,
        ST_FLUSH
    } state_t;

    state_t             state_reg;
    logic [2:0]         s_reg;
    logic [2:0]         d_reg;
    logic [2:0]         n_reg;
    logic [W-1:0]       amt_reg;
    logic [W-1:0]       rem_reg;
    logic [TW-1:0]      total_reg;
    logic [2:0]         best_start_reg;
    logic [TW-1:0]      best_total_reg;
    logic [W-1:0]       best_left_reg;
    logic [DENOM_W-1:0] work_counts_reg [LIM];
    logic [DENOM_W-1:0] best_counts_reg [LIM];
    logic               m_valid_reg;
    logic               m_last_reg;
    logic [RESULT_W-1:0] m_data_reg;

    logic [2:0]         n_calc;
    logic [DENOM_W-1:0] cur_denom;
    logic               better;

    function automatic logic [15:0] sat16(input logic [TW-1:0] v);
        return (v > TW'(17'h0FFFF)) ? 16'hFFFF : 16'(v);
    endfunction

    always_comb
    begin
        if (active_count == 3'd0)
            n_calc = 3'd1;
        else if (active_count > 3'(LIM))
            n_calc = 3'(LIM);
        else
            n_calc = active_count;
    end

    assign cur_denom    = denoms[d_reg];
    assign better       = (s_reg == 3'd0) || (total_reg < best_total_reg);
    assign s_ready      = (state_reg == ST_IDLE);
    assign div_start    = (state_reg == ST_STEP) && (cur_denom != '0);
    assign div_dividend = rem_reg;
    assign div_divisor  = cur_denom;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
    assign m_last       = m_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            s_reg          <= '0;
            d_reg          <= '0;
            n_reg          <= 3'd1;
            best_start_reg <= '0;
            best_total_reg <= '0;
            best_left_reg  <= '0;
            m_valid_reg    <= 1'b0;
            m_last_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_valid)
                    begin
                        amt_reg   <= W'(amount);
                        n_reg     <= n_calc;
                        s_reg     <= '0;
                        state_reg <= ST_INIT;
                    end
                end
                ST_INIT:
                begin
                    d_reg     <= s_reg;
                    rem_reg   <= amt_reg;
                    total_reg <= '0;
                    state_reg <= ST_STEP;
                end
                ST_STEP:
                begin
                    if (cur_denom == '0)
                    begin
                        work_counts_reg[d_reg[IW-1:0]] <= '0;
                        state_reg <= ST_ADV;
                    end
                    else
                    begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (div_done)
                    begin
                        work_counts_reg[d_reg[IW-1:0]] <= sat16(TW'(div_quot));
                        total_reg <= total_reg + TW'(div_quot);
                        rem_reg   <= div_rem;
                        state_reg <= ST_ADV;
                    end
                end
                ST_ADV:
                begin
                    if (d_reg == 3'd0)
                    begin
                        state_reg <= ST_EVAL;
                    end
                    else
                    begin
                        d_reg     <= d_reg - 3'd1;
                        state_reg <= ST_STEP;
                    end
                end
                ST_EVAL:
                begin
                    if (better)
                    begin
                        best_total_reg  <= total_reg;
                        best_start_reg  <= s_reg;
                        best_left_reg   <= rem_reg;
                        best_counts_reg <= work_counts_reg;
                    end
                    d_reg <= better ? s_reg : best_start_reg;
                    if (s_reg == n_reg - 3'd1)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        s_reg     <= s_reg + 3'd1;
                        state_reg <= ST_INIT;
                    end
                end
                ST_OUT:
                begin
                    if (!m_valid_reg || m_ready)
                    begin
                        m_valid_reg <= 1'b1;
                        if (d_reg == 3'd0)
                        begin
                            m_data_reg <= {sat16(best_total_reg),
                                           sat16(TW'(best_left_reg)),
                                           best_counts_reg[d_reg[IW-1:0]], cur_denom};
                            m_last_reg <= 1'b1;
                            state_reg  <= ST_FLUSH;
                        end
                        else
                        begin
                            m_data_reg <= {16'd0, 16'd0,
                                           best_counts_reg[d_reg[IW-1:0]], cur_denom};
                            m_last_reg <= 1'b0;
                            d_reg      <= d_reg - 3'd1;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (m_ready)
                    begin
                        m_valid_reg <= 1'b0;
                        m_last_reg  <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`include "assert_macros.svh"

    `BGCC_ASSERT(a_idle_no_result, (state_reg == ST_IDLE) |-> !m_valid_reg, "result left in idle")
    `BGCC_ASSERT(a_done_in_wait, div_done |-> (state_reg == ST_WAIT), "divider done out of turn")
    `BGCC_ASSERT(a_out_range, (state_reg == ST_OUT) |-> (d_reg <= best_start_reg), "bad index")
    `BGCC_ASSERT_NEXT(a_last_ends, m_valid_reg && m_last_reg && m_ready, state_reg == ST_IDLE, "no return to idle")

endmodule

// ----- design/best_greedy_coin_change.sv -----
`timescale 1ns / 1ps

// Channel    Direction  Payload (lowest bit up)
// s_axis     in         tdata: amount[15:0]
// m_axis     out        tdata: denomination, note_count, leftover, total_notes; tlast: last
// cfg        in         cfg_index selects denom_0..denom_6 or active_count, cfg_data value
//
// The shared restoring divider, one quotient bit per cycle, serves every greedy step of
// every start in turn. A zero denomination skips the division and records a count of zero.
// Reset restores the default denominations and clears the sequencer; no clearing pass is needed.
// Input is taken only while the block is idle; a stalled output holds the sequencer in place.

module best_greedy_coin_change #(
    parameter int MAX_DENOMS  = bgcc_pkg::DEF_MAX_DENOMS,
    parameter int AMOUNT_BITS = bgcc_pkg::DEF_AMOUNT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // amount
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // denomination, note_count, leftover, total_notes
    output logic [bgcc_pkg::RESULT_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast,  // last
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bgcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bgcc_pkg::DENOM_W-1:0]    cfg_data
);
    import bgcc_pkg::*;

    denom_arr_t               denom_reg;
    logic [2:0]               active_reg;
    logic                     div_start;
    logic                     div_done;
    logic [AMOUNT_BITS-1:0]   div_dividend;
    logic [DENOM_W-1:0]       div_divisor;
    logic [AMOUNT_BITS-1:0]   div_quot;
    logic [AMOUNT_BITS-1:0]   div_rem;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            denom_reg  <= DENOM_RESET;
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index < CFG_IDX_W'(NREG))
                denom_reg[cfg_index[2:0]] <= cfg_data;
            else if (cfg_index == REG_ACTIVE_COUNT)
                active_reg <= cfg_data[2:0];
        end
    end

    bgcc_ctrl #(
        .MAX_DENOMS  (MAX_DENOMS),
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_valid      (s_axis_tvalid),
        .s_ready      (s_axis_tready),
        .amount       (s_axis_tdata),
        .denoms       (denom_reg),
        .active_count (active_reg),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quot     (div_quot),
        .div_rem      (div_rem),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .m_data       (m_axis_tdata),
        .m_last       (m_axis_tlast)
    );

    bgcc_div #(
        .W (AMOUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

endmodule
